### hdl/sdtw_pkg.sv
// package for the subsequence dtw search block
// shared types, widths, states and helpers; no dependencies
package sdtw_pkg;

    localparam int QUERY_LENGTH = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int COST_BITS = 32;
    localparam int QIDX_BITS = (QUERY_LENGTH > 1) ? $clog2(QUERY_LENGTH) : 1;
    localparam int POS_BITS = 16;
    localparam logic [COST_BITS-1:0] COST_INF = '1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REF = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  query_index;
        logic signed [15:0] sample;
        logic        first_of_reference;
        logic        last_of_reference;
    } sdtw_in_t;

    typedef struct packed {
        logic [31:0] best_distance;
        logic [15:0] best_position;
    } sdtw_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_CELL,
        ST_FINISH
    } sdtw_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_query;
        logic capture;
        logic clear_row;
        logic read_row;
        logic update_row;
        logic finish;
        logic restart_best;
        logic emit;
    } sdtw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_row;
        logic last_update;
        logic is_ref;
        logic first;
        logic last;
        logic out_full;
    } sdtw_stat_t;

endpackage

### hdl/sdtw_ctrl.sv
// sequencer for the subsequence dtw search
// depends on sdtw_pkg
module sdtw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdtw_pkg::sdtw_stat_t stat,
    output sdtw_pkg::sdtw_cmd_t  cmd
);
    import sdtw_pkg::*;

    sdtw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.out_full;
                if (in_valid && !stat.out_full)
                begin
                    cmd.capture = 1'b1;
                    cmd.load_query = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (stat.last_row)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (!stat.is_ref)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.read_row = 1'b1;
                    cmd.restart_best = stat.first;
                    state_next = ST_CELL;
                end
            end
            ST_CELL:
            begin
                cmd.update_row = 1'b1;
                if (stat.last_update)
                    state_next = ST_FINISH;
                else
                    cmd.read_row = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                cmd.emit = stat.last;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### hdl/sdtw_datapath.sv
// cost column memory, query memory, cell update and best tracking
// depends on sdtw_pkg
module sdtw_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdtw_pkg::sdtw_in_t   in_data,
    input  sdtw_pkg::sdtw_cmd_t  cmd,
    output sdtw_pkg::sdtw_stat_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdtw_pkg::sdtw_out_t  out_data
);
    import sdtw_pkg::*;

    logic signed [SAMPLE_BITS-1:0] query_mem [QUERY_LENGTH];
    logic [COST_BITS-1:0] cost_mem [QUERY_LENGTH];

    sdtw_in_t req_reg;
    logic [QIDX_BITS-1:0] row_reg;
    logic [QIDX_BITS-1:0] rd_row_reg;
    logic signed [SAMPLE_BITS-1:0] q_rd_reg;
    logic [COST_BITS-1:0] left_rd_reg;
    logic fresh_reg;
    logic [COST_BITS-1:0] above_reg, diag_reg, last_cost_reg;
    logic [COST_BITS-1:0] best_cost_reg;
    logic [POS_BITS-1:0] best_index_reg, ref_pos_reg;
    logic out_valid_reg;
    sdtw_out_t out_reg;

    logic [SAMPLE_BITS:0] diff, absd;
    logic [COST_BITS-1:0] left_eff, mn, cell_cost;
    logic [COST_BITS:0] sum;
    logic [COST_BITS-1:0] best_cost_cur;
    logic [POS_BITS-1:0] best_index_cur, ref_pos_cur;

    assign stat.last_row = (row_reg == QIDX_BITS'(QUERY_LENGTH - 1));
    // the row being updated is the final query row
    assign stat.last_update = (rd_row_reg == QIDX_BITS'(QUERY_LENGTH - 1));
    assign stat.is_ref = (req_reg.command == CMD_REF);
    assign stat.first = req_reg.first_of_reference;
    assign stat.last = req_reg.last_of_reference;
    assign stat.out_full = out_valid_reg;

    // a restart treats the stored column as infinity
    assign left_eff = fresh_reg ? COST_INF : left_rd_reg;
    assign diff = {q_rd_reg[SAMPLE_BITS-1], q_rd_reg}
                  - {req_reg.sample[SAMPLE_BITS-1], req_reg.sample};
    assign absd = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;

    always_comb
    begin
        mn = above_reg;
        if (left_eff < mn)
            mn = left_eff;
        if (diag_reg < mn)
            mn = diag_reg;
        sum = {1'b0, mn} + (COST_BITS+1)'(absd);
        if (mn == COST_INF || sum >= {1'b0, COST_INF})
            cell_cost = COST_INF;
        else
            cell_cost = sum[COST_BITS-1:0];
    end

    always_comb
    begin
        best_cost_cur = best_cost_reg;
        best_index_cur = best_index_reg;
        ref_pos_cur = ref_pos_reg;
        if (fresh_reg)
        begin
            best_cost_cur = COST_INF;
            best_index_cur = '0;
            ref_pos_cur = '0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_query && in_data.command == CMD_LOAD
            && 32'(in_data.query_index) < QUERY_LENGTH)
            query_mem[QIDX_BITS'(in_data.query_index)] <= in_data.sample;
        if (cmd.clear_row)
            cost_mem[row_reg] <= COST_INF;
        else if (cmd.update_row)
            cost_mem[rd_row_reg] <= cell_cost;
        if (cmd.read_row)
        begin
            q_rd_reg <= query_mem[row_reg];
            left_rd_reg <= cost_mem[row_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_data;
        if (cmd.read_row)
            rd_row_reg <= row_reg;
        if (cmd.restart_best || cmd.read_row && row_reg == '0)
        begin
            above_reg <= '0;
            diag_reg <= '0;
        end
        else if (cmd.update_row)
        begin
            above_reg <= cell_cost;
            diag_reg <= left_eff;
        end
        if (cmd.update_row)
            last_cost_reg <= cell_cost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            fresh_reg <= 1'b0;
            best_cost_reg <= COST_INF;
            best_index_reg <= '0;
            ref_pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_row || cmd.read_row)
                row_reg <= stat.last_row ? '0 : row_reg + 1'b1;
            else if (cmd.capture)
                row_reg <= '0;
            if (cmd.restart_best)
                fresh_reg <= 1'b1;
            else if (cmd.finish)
                fresh_reg <= 1'b0;
            if (cmd.finish)
            begin
                if (last_cost_reg < best_cost_cur)
                begin
                    best_cost_reg <= last_cost_reg;
                    best_index_reg <= ref_pos_cur;
                end
                else
                begin
                    best_cost_reg <= best_cost_cur;
                    best_index_reg <= best_index_cur;
                end
                ref_pos_reg <= ref_pos_cur + 1'b1;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (last_cost_reg < best_cost_cur)
            begin
                out_reg.best_distance <= 32'(last_cost_reg);
                out_reg.best_position <= ref_pos_cur;
            end
            else
            begin
                out_reg.best_distance <= 32'(best_cost_cur);
                out_reg.best_position <= best_index_cur;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

### hdl/subsequence_dtw_search_top.sv
// subsequence dtw search: one input channel of requests, one result channel
// depends on sdtw_pkg, sdtw_ctrl, sdtw_datapath
//
// usage: send query loads (command 0) by index, then reference samples
// (command 1); first_of_reference restarts the search, last_of_reference
// produces one result with the lowest last-row cost and its end position.
// a reference sample walks every query row: each row is one read and one
// update of the cost column memory, which reads one row while it writes
// the row before, one row per cycle. a result is captured in the finish
// state after the final row update and sits in an output register until
// taken; the next request is only taken once that register is empty, so
// a stalled receiver holds off the input side. after reset the cost
// column is cleared by a pass over all QUERY_LENGTH rows during which no
// request is accepted. query memory is not cleared.
module subsequence_dtw_search_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdtw_pkg::sdtw_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sdtw_pkg::sdtw_out_t out_data
);
    import sdtw_pkg::*;

    sdtw_cmd_t  cmd;
    sdtw_stat_t stat;

    sdtw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .cmd(cmd)
    );

    sdtw_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

### hdl/sdtw_checker.sv
// port level checks for the subsequence dtw search
// depends on sdtw_pkg; bound to subsequence_dtw_search_top
module sdtw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input sdtw_pkg::sdtw_in_t in_data,
    input logic               out_valid,
    input logic               out_ready,
    input sdtw_pkg::sdtw_out_t out_data
);
    import sdtw_pkg::*;

    // a result waits until taken, unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // no new request while a result is pending
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken with result pending");

    // a request is never taken back to back with the one before it
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back to back requests");

    // a query load makes no result from its read state
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command == CMD_LOAD |=> ##1 !$rose(out_valid))
        else $error("result after query load");

endmodule

bind subsequence_dtw_search_top sdtw_checker u_sdtw_checker (.*);

### dv/subsequence_dtw_search_checker.sv
// checker for the subsequence dtw search block: predicts results from accepted requests
// and compares them with accepted results; depends on sdtw_pkg
`timescale 1ns / 100ps

module subsequence_dtw_search_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  sdtw_pkg::sdtw_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  sdtw_pkg::sdtw_out_t out_data,
    output int                  fail_count,
    output int                  pending
);
    import sdtw_pkg::*;

    logic signed [SAMPLE_BITS-1:0] query_mem [QUERY_LENGTH];
    logic [COST_BITS-1:0] column [QUERY_LENGTH];
    logic [COST_BITS-1:0] lowest_cost;
    logic [15:0] lowest_pos;
    logic [15:0] ref_pos;
    sdtw_out_t match_queue [$];

    function automatic logic [COST_BITS-1:0] cost_sum(logic [COST_BITS-1:0] d,
                                                      logic [COST_BITS-1:0] m);
        logic [COST_BITS:0] s;
        if (d == COST_INF || m == COST_INF)
            return COST_INF;
        s = {1'b0, d} + {1'b0, m};
        return (s > {1'b0, COST_INF}) ? COST_INF : s[COST_BITS-1:0];
    endfunction

    task automatic restart_search();
        foreach (column[i])
            column[i] = COST_INF;
        lowest_cost = COST_INF;
        lowest_pos = '0;
        ref_pos = '0;
    endtask

    task automatic process_request(sdtw_in_t req);
        logic [COST_BITS-1:0] above, diag, left, m, d;
        logic signed [SAMPLE_BITS+1:0] diff;
        sdtw_out_t res;
        above = '0;
        diag = '0;
        if (req.command == CMD_LOAD)
        begin
            if (req.query_index < QUERY_LENGTH)
                query_mem[req.query_index] = req.sample;
            return;
        end
        if (req.first_of_reference)
            restart_search();
        for (int r = 0; r < QUERY_LENGTH; r++)
        begin
            diff = query_mem[r] - req.sample;
            d = COST_BITS'((diff < 0) ? -diff : diff);
            left = column[r];
            m = above;
            if (left < m)
                m = left;
            if (diag < m)
                m = diag;
            column[r] = cost_sum(d, m);
            diag = left;
            above = column[r];
        end
        if (column[QUERY_LENGTH-1] < lowest_cost)
        begin
            lowest_cost = column[QUERY_LENGTH-1];
            lowest_pos = ref_pos;
        end
        ref_pos = ref_pos + 16'd1;
        if (req.last_of_reference)
        begin
            res.best_distance = lowest_cost;
            res.best_position = lowest_pos;
            match_queue.push_back(res);
        end
    endtask

    initial
    begin
        fail_count = 0;
        foreach (query_mem[i])
            query_mem[i] = '0;
        restart_search();
    end

    assign pending = match_queue.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (match_queue.size() == 0)
                begin
                    $error("unexpected result %h", out_data);
                    fail_count++;
                end
                else
                begin
                    sdtw_out_t exp_res;
                    exp_res = match_queue.pop_front();
                    if (out_data.best_distance !== exp_res.best_distance)
                    begin
                        $error("best_distance expected %h actual %h",
                               exp_res.best_distance, out_data.best_distance);
                        fail_count++;
                    end
                    if (out_data.best_position !== exp_res.best_position)
                    begin
                        $error("best_position expected %h actual %h",
                               exp_res.best_position, out_data.best_position);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                process_request(in_data);
        end
    end
endmodule

### dv/subsequence_dtw_search_top_test.sv
// testbench top for subsequence_dtw_search_top: drives requests with random gaps,
// stalls the result side, and reports the verdict; depends on sdtw_pkg and the checker
`timescale 1ns / 100ps

module subsequence_dtw_search_top_test;
    import sdtw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sdtw_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sdtw_out_t out_data;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    always #1 clk = ~clk;

    subsequence_dtw_search_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    subsequence_dtw_search_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 300);
    endfunction

    // called at a falling edge; valid stays high into the next request when there is no gap
    task automatic send_request(sdtw_in_t req);
        int gap;
        gap = stim_done ? 0 : gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        in_data <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_query(logic [7:0] idx, logic [15:0] smp);
        sdtw_in_t req;
        req = sdtw_in_t'($urandom);
        req.command = CMD_LOAD;
        req.query_index = idx;
        req.sample = smp;
        send_request(req);
    endtask

    task automatic send_reference(logic [15:0] smp, logic first, logic last);
        sdtw_in_t req;
        req = sdtw_in_t'($urandom);
        req.command = CMD_REF;
        req.sample = smp;
        req.first_of_reference = first;
        req.last_of_reference = last;
        send_request(req);
    endtask

    // random result-side stalls
    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) < 3)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 60)
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[subsequence_dtw_search_top] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] random_sample(int mode);
        case (mode)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int items;
        int mode;
        int run_len;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: full query at extremes, then edge references
        for (int i = 0; i < QUERY_LENGTH; i++)
            send_query(i[7:0], (i % 2) ? 16'h7FFF : 16'h8000);
        send_reference(16'h8000, 1'b1, 1'b0);
        send_reference(16'h7FFF, 1'b0, 1'b1);
        send_reference(16'h0000, 1'b0, 1'b1);
        send_reference(16'h7FFF, 1'b1, 1'b1);
        for (int i = 0; i < 20; i++)
            send_reference(16'h8000 ^ (i[0] ? 16'hFFFF : 16'h0), i == 0, i == 19);

        // random: mostly small-valued queries and runs that match
        items = QUERY_LENGTH + 24;
        while (items < 1600)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
            begin
                for (int i = 0; i < QUERY_LENGTH; i++)
                    send_query(i[7:0], random_sample($urandom_range(0, 9) < 8 ? 2 : 3));
                items += QUERY_LENGTH;
            end
            else if (mode < 3)
            begin
                send_query(8'($urandom), random_sample($urandom_range(0, 4)));
                items++;
            end
            else
            begin
                run_len = $urandom_range(1, 12);
                for (int i = 0; i < run_len; i++)
                begin
                    send_reference(random_sample($urandom_range(0, 9) < 7 ? 2 :
                                                 $urandom_range(0, 3)),
                                   (i == 0) && ($urandom_range(0, 4) != 0),
                                   (i == run_len - 1) || ($urandom_range(0, 19) == 0));
                    items++;
                end
            end
        end

        in_valid <= 1'b0;
        stim_done = 1'b1;
        while (pending != 0)
            @(posedge clk);
        repeat (2 * QUERY_LENGTH + 10)
            @(posedge clk);
        if (fail_count == 0)
            $display("[subsequence_dtw_search_top] OK");
        else
            $display("[subsequence_dtw_search_top] ERROR");
        $finish;
    end
endmodule

### subsequence_dtw_search_top.f
hdl/sdtw_pkg.sv
hdl/sdtw_ctrl.sv
hdl/sdtw_datapath.sv
hdl/subsequence_dtw_search_top.sv
hdl/sdtw_checker.sv
dv/subsequence_dtw_search_checker.sv
dv/subsequence_dtw_search_top_test.sv
